### design/ppr_pkg.sv
// Shared types, constants and divider step for the perspective point rasterizer.
`timescale 1ns / 1ps
package ppr_pkg;

  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_M00 = 3'd0;
  localparam logic [2:0] REG_M11 = 3'd1;
  localparam logic [2:0] REG_M20 = 3'd2;
  localparam logic [2:0] REG_M21 = 3'd3;
  localparam logic [2:0] REG_M22 = 3'd4;
  localparam logic [2:0] REG_M23 = 3'd5;
  localparam logic [2:0] REG_M32 = 3'd6;
  localparam logic [2:0] REG_M33 = 3'd7;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // Divider: 32 quotient bits, two per pipeline stage
  localparam int QBITS       = 32;
  localparam int BITS_PER_ST = 2;
  localparam int DIV_STAGES  = QBITS / BITS_PER_ST;

  // One lane of the restoring divider
  typedef struct packed {
    logic [49:0] rem;
    logic [31:0] nlo;
    logic [31:0] quo;
    logic [48:0] den;
    logic        neg;
    logic        big;
  } div_lane_t;

  // Advance one lane by BITS_PER_ST quotient bits
  function automatic div_lane_t div_step(input div_lane_t a);
    div_lane_t  b;
    logic [49:0] t;
    b = a;
    for (int i = 0; i < BITS_PER_ST; i++) begin
      t     = {b.rem[48:0], b.nlo[31]};
      b.nlo = {b.nlo[30:0], 1'b0};
      if (t >= {1'b0, b.den}) begin
        b.rem = t - {1'b0, b.den};
        b.quo = {b.quo[30:0], 1'b1};
      end else begin
        b.rem = t;
        b.quo = {b.quo[30:0], 1'b0};
      end
    end
    return b;
  endfunction

  // Magnitude of a 50-bit signed sum, shifted into divider lane form
  function automatic div_lane_t div_init(input logic signed [49:0] num,
                                         input logic signed [49:0] den);
    div_lane_t   l;
    logic [49:0] un;
    logic [49:0] ud;
    un = num[49] ? 50'(-num) : 50'(num);
    ud = den[49] ? 50'(-den) : 50'(den);
    l.rem = 50'(un[48:16]);
    l.nlo = {un[15:0], 16'h0000};
    l.quo = '0;
    l.den = ud[48:0];
    l.neg = num[49] ^ den[49];
    // Quotient reaches 2^32 exactly when the upper dividend part reaches den
    l.big = (49'(un[48:16]) >= ud[48:0]);
    return l;
  endfunction

  // Sign and saturate a finished quotient
  function automatic logic signed [31:0] div_final(input div_lane_t l);
    logic signed [31:0] r;
    if (l.neg) begin
      if (l.big || l.quo[31]) r = 32'sh8000_0000;
      else                    r = -$signed(l.quo);
    end else begin
      if (l.big || l.quo[31]) r = 32'sh7FFF_FFFF;
      else                    r = $signed(l.quo);
    end
    return r;
  endfunction

endpackage

### design/perspective_point_rasterizer.sv
// Perspective point rasterizer: matrix multiply, perspective divide, raster map.
// One camera-space point is accepted per cycle unless in_stall is high. Each
// point passes the product stage, the pipelined restoring divider that yields
// two quotient bits per stage for x, y and depth in parallel lanes, the finish
// stage and the output registers. The whole
// pipeline holds while the output item is stalled; in_stall follows out_stall
// whenever an output item is waiting.
`timescale 1ns / 1ps
module perspective_point_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_cam_x,
  input  logic signed [31:0] in_cam_y,
  input  logic signed [31:0] in_cam_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible,
  output logic               out_divide_fault,
  output logic [8:0]         out_pixel_x,
  output logic [8:0]         out_pixel_y,
  output logic signed [31:0] out_depth_out
);

  localparam int NDIV = ppr_pkg::DIV_STAGES;

  logic signed [31:0] m00_r, m11_r, m20_r, m21_r, m22_r, m23_r, m32_r, m33_r;
  logic               adv;

  // Product stage
  logic               v1_r;
  logic signed [63:0] pxx_r, pzx_r, pyy_r, pzy_r, pzz_r, pzw_r;

  // Divider stages
  logic                 vd_r [NDIV+1];
  logic                 fd_r [NDIV+1];
  ppr_pkg::div_lane_t   ln_r [NDIV+1][3];

  // Finish stage
  logic               vf_r, ff_r;
  logic               vis_nxt;
  logic signed [31:0] nx_r, ny_r, nz_r;

  // Sums before the divide
  logic signed [49:0] hx, hy, hz, hw;

  // Raster mapping
  logic [17:0] rv_x, rv_y;
  logic [30:0] rp_x, rp_y;
  logic [13:0] rs_x, rs_y;
  logic [8:0]  pix_x_nxt, pix_y_nxt;

  // Move everything one stage when the output slot is free
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m00_r <= ppr_pkg::Q_ONE;
      m11_r <= ppr_pkg::Q_ONE;
      m20_r <= '0;
      m21_r <= '0;
      m22_r <= ppr_pkg::Q_ONE;
      m23_r <= '0;
      m32_r <= '0;
      m33_r <= ppr_pkg::Q_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppr_pkg::REG_M00: m00_r <= cfg_wdata;
        ppr_pkg::REG_M11: m11_r <= cfg_wdata;
        ppr_pkg::REG_M20: m20_r <= cfg_wdata;
        ppr_pkg::REG_M21: m21_r <= cfg_wdata;
        ppr_pkg::REG_M22: m22_r <= cfg_wdata;
        ppr_pkg::REG_M23: m23_r <= cfg_wdata;
        ppr_pkg::REG_M32: m32_r <= cfg_wdata;
        ppr_pkg::REG_M33: m33_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Floor each product to Q16.16 and add up the homogeneous coordinates
  always_comb begin
    hx = 50'(pxx_r >>> 16) + 50'(pzx_r >>> 16);
    hy = 50'(pyy_r >>> 16) + 50'(pzy_r >>> 16);
    hz = 50'(pzz_r >>> 16) + 50'(m32_r);
    hw = 50'(pzw_r >>> 16) + 50'(m33_r);
  end

  // Map NDC to raster; v stays in [0, 2^17] for visible points
  always_comb begin
    rv_x = 18'(nx_r + ppr_pkg::Q_ONE);
    rv_y = 18'(ppr_pkg::Q_ONE - ny_r);
    rp_x = 31'(rv_x) * 31'(ppr_pkg::IMAGE_WIDTH);
    rp_y = 31'(rv_y) * 31'(ppr_pkg::IMAGE_HEIGHT);
    rs_x = rp_x[30:17];
    rs_y = rp_y[30:17];
    if (rs_x > 14'(ppr_pkg::IMAGE_WIDTH - 1)) pix_x_nxt = 9'(ppr_pkg::IMAGE_WIDTH - 1);
    else                                      pix_x_nxt = rs_x[8:0];
    if (rs_y > 14'(ppr_pkg::IMAGE_HEIGHT - 1)) pix_y_nxt = 9'(ppr_pkg::IMAGE_HEIGHT - 1);
    else                                       pix_y_nxt = rs_y[8:0];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      vf_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int s = 0; s <= NDIV; s++) vd_r[s] <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_valid;
      vd_r[0] <= v1_r;
      for (int s = 1; s <= NDIV; s++) vd_r[s] <= vd_r[s-1];
      vf_r      <= vd_r[NDIV];
      out_valid <= vf_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx_r <= in_cam_x * m00_r;
      pzx_r <= in_cam_z * m20_r;
      pyy_r <= in_cam_y * m11_r;
      pzy_r <= in_cam_z * m21_r;
      pzz_r <= in_cam_z * m22_r;
      pzw_r <= in_cam_z * m23_r;

      fd_r[0]    <= (hw == '0);
      ln_r[0][0] <= ppr_pkg::div_init(hx, hw);
      ln_r[0][1] <= ppr_pkg::div_init(hy, hw);
      ln_r[0][2] <= ppr_pkg::div_init(hz, hw);

      for (int s = 1; s <= NDIV; s++) begin
        fd_r[s] <= fd_r[s-1];
        for (int l = 0; l < 3; l++) ln_r[s][l] <= ppr_pkg::div_step(ln_r[s-1][l]);
      end

      ff_r <= fd_r[NDIV];
      nx_r <= ppr_pkg::div_final(ln_r[NDIV][0]);
      ny_r <= ppr_pkg::div_final(ln_r[NDIV][1]);
      nz_r <= ppr_pkg::div_final(ln_r[NDIV][2]);

      out_divide_fault <= ff_r;
      out_visible      <= vis_nxt;
      out_pixel_x      <= vis_nxt ? pix_x_nxt : '0;
      out_pixel_y      <= vis_nxt ? pix_y_nxt : '0;
      out_depth_out    <= vis_nxt ? nz_r : '0;
    end
  end

  // Clip test on the finished quotients
  always_comb begin
    vis_nxt = !ff_r && (nx_r <= ppr_pkg::Q_ONE) && (nx_r >= -ppr_pkg::Q_ONE)
              && (ny_r <= ppr_pkg::Q_ONE) && (ny_r >= -ppr_pkg::Q_ONE);
  end

endmodule

### design/ppr_checker.sv
// Port-level checks for the perspective point rasterizer, bound to the top level.
`timescale 1ns / 1ps
module ppr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_visible,
  input logic               out_divide_fault,
  input logic [8:0]         out_pixel_x,
  input logic [8:0]         out_pixel_y,
  input logic signed [31:0] out_depth_out
);

  // A faulted item is never visible
  a_fault_invisible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> !out_visible)
    else $error("fault item marked visible");

  // Culled items carry zero payload
  a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |->
      out_pixel_x == '0 && out_pixel_y == '0 && out_depth_out == '0)
    else $error("culled item with payload");

  // Input is held back exactly while a result waits
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_depth_out) && $stable(out_pixel_x))
    else $error("stalled item changed");

endmodule

bind perspective_point_rasterizer ppr_checker u_ppr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_visible      (out_visible),
  .out_divide_fault (out_divide_fault),
  .out_pixel_x      (out_pixel_x),
  .out_pixel_y      (out_pixel_y),
  .out_depth_out    (out_depth_out)
);
